>>> hdl/rsi_pkg.sv
package rsi_pkg;

  localparam int SqrtBits = 36;
  localparam int DivBits  = 33;

  localparam logic [7:0] CfgCenterX = 8'd0;
  localparam logic [7:0] CfgCenterY = 8'd1;
  localparam logic [7:0] CfgCenterZ = 8'd2;
  localparam logic [7:0] CfgRadius  = 8'd3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rsi_in_t;

  typedef struct packed {
    logic               hit;
    logic               inside_res;
    logic [30:0]        distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } rsi_out_t;

  typedef struct packed {
    logic        hit;
    logic [34:0] b;
    rsi_in_t     ray;
  } rsi_sq_side_t;

  typedef struct packed {
    logic              hit;
    logic              inner;
    logic [30:0]       distance;
    logic [2:0][31:0]  p;
    logic [2:0]        neg;
    logic [2:0]        ovf;
  } rsi_div_side_t;

endpackage

>>> hdl/rsi_isqrt.sv
module rsi_isqrt
  import rsi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [71:0]               x_i,
  input  rsi_sq_side_t              side_i,
  output logic                      valid_o,
  output logic [SqrtBits-1:0]       root_o,
  output rsi_sq_side_t              side_o
);

  logic [71:0]         x_q    [SqrtBits];
  logic [SqrtBits-1:0] res_q  [SqrtBits];
  logic [73:0]         sq_q   [SqrtBits];
  rsi_sq_side_t        side_q [SqrtBits];
  logic                vld_q  [SqrtBits];

  for (genvar k = 0; k < SqrtBits; k++) begin : g_stage
    localparam int Bit = SqrtBits - 1 - k;
    logic [71:0]         x_in;
    logic [SqrtBits-1:0] res_in;
    logic [73:0]         sq_in;
    rsi_sq_side_t        side_in;
    logic                vld_in;
    logic [73:0]         cand_sq;
    logic                take;

    if (k == 0) begin : g_first
      assign x_in    = x_i;
      assign res_in  = '0;
      assign sq_in   = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign res_in  = res_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign cand_sq = sq_in + (74'(res_in) << (Bit + 1)) + (74'(1) << (2 * Bit));
    assign take    = {2'b00, x_in} >= cand_sq;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in;
        side_q[k] <= side_in;
        if (take) begin
          res_q[k] <= res_in | (SqrtBits'(1) << Bit);
          sq_q[k]  <= cand_sq;
        end else begin
          res_q[k] <= res_in;
          sq_q[k]  <= sq_in;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtBits-1];
  assign root_o  = res_q[SqrtBits-1];
  assign side_o  = side_q[SqrtBits-1];

endmodule

>>> hdl/rsi_div.sv
module rsi_div
  import rsi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [30:0]              radius_i,
  input  logic [2:0][62:0]         num_i,
  input  rsi_div_side_t            side_i,
  output logic                     valid_o,
  output logic [2:0][DivBits-1:0]  quot_o,
  output rsi_div_side_t            side_o
);

  logic [2:0][62:0]        rem_q  [DivBits];
  logic [2:0][DivBits-1:0] quo_q  [DivBits];
  rsi_div_side_t           side_q [DivBits];
  logic                    vld_q  [DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    localparam int Bit = DivBits - 1 - k;
    logic [2:0][62:0]        rem_in;
    logic [2:0][DivBits-1:0] quo_in;
    rsi_div_side_t           side_in;
    logic                    vld_in;
    logic [62:0]             dsh;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign dsh = 63'(radius_i) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_q[k][l] <= rem_in[l] - dsh;
            quo_q[k][l] <= quo_in[l] | (DivBits'(1) << Bit);
          end else begin
            rem_q[k][l] <= rem_in[l];
            quo_q[k][l] <= quo_in[l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[DivBits-1];
  assign quot_o  = quo_q[DivBits-1];
  assign side_o  = side_q[DivBits-1];

endmodule

>>> hdl/ray_sphere_intersect.sv
// Throughput: one request per cycle while the output is not stalled; the square
// root (36 stages, one root bit each) and the normal divider (33 stages, one
// quotient bit each) are fully pipelined.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads center 0 and radius 1.0.
module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rsi_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsi_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [31:0] c_q [3];
  logic [30:0]        r_q;
  logic               adv;

  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q[0] <= '0;
      c_q[1] <= '0;
      c_q[2] <= '0;
      r_q    <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCenterX: c_q[0] <= cfg_data_i;
        CfgCenterY: c_q[1] <= cfg_data_i;
        CfgCenterZ: c_q[2] <= cfg_data_i;
        CfgRadius:  r_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] o_in [3];
  logic signed [31:0] d_in [3];
  assign o_in[0] = in_data_i.origin_x;
  assign o_in[1] = in_data_i.origin_y;
  assign o_in[2] = in_data_i.origin_z;
  assign d_in[0] = in_data_i.dir_x;
  assign d_in[1] = in_data_i.dir_y;
  assign d_in[2] = in_data_i.dir_z;

  logic               v1_vld_q, v2_vld_q, v3_vld_q, v4_vld_q, v5_vld_q;
  rsi_in_t            ray1_q, ray2_q, ray3_q, ray4_q, ray5_q;
  logic signed [32:0] v1_q [3];
  logic signed [31:0] d1_q [3];
  logic signed [34:0] term2_q [3];
  logic [65:0]        vsq2_q [3];
  logic signed [36:0] b3_q;
  logic [67:0]        vv3_q;
  logic               bpos4_q;
  logic [34:0]        b4_q, b5_q;
  logic [69:0]        bb4_q;
  logic [61:0]        rr4_q;
  logic [67:0]        vv4_q;
  logic               hit5_q;
  logic [71:0]        disc5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_vld_q <= 1'b0;
      v2_vld_q <= 1'b0;
      v3_vld_q <= 1'b0;
      v4_vld_q <= 1'b0;
      v5_vld_q <= 1'b0;
    end else if (adv) begin
      v1_vld_q <= in_valid_i;
      v2_vld_q <= v1_vld_q;
      v3_vld_q <= v2_vld_q;
      v4_vld_q <= v3_vld_q;
      v5_vld_q <= v4_vld_q;
    end
  end

  logic signed [64:0] prod2 [3];
  logic [32:0]        vmag2 [3];
  logic signed [36:0] dot3;
  logic [70:0]        lhs5;
  logic [72:0]        disc5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod2[i] = v1_q[i] * 65'(d1_q[i]);
      vmag2[i] = v1_q[i][32] ? 33'(-v1_q[i]) : 33'(v1_q[i]);
    end
    dot3 = 37'(term2_q[0]) + 37'(term2_q[1]) + 37'(term2_q[2]);
    lhs5  = 71'(bb4_q) + 71'(rr4_q);
    disc5 = 73'(lhs5) - 73'(vv4_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray1_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= 33'(o_in[i]) - 33'(c_q[i]);
        d1_q[i] <= d_in[i];
      end
      ray2_q <= ray1_q;
      for (int i = 0; i < 3; i++) begin
        term2_q[i] <= prod2[i][64:30];
        vsq2_q[i]  <= vmag2[i] * vmag2[i];
      end
      ray3_q <= ray2_q;
      b3_q   <= -dot3;
      vv3_q  <= 68'(vsq2_q[0]) + 68'(vsq2_q[1]) + 68'(vsq2_q[2]);
      ray4_q  <= ray3_q;
      bpos4_q <= b3_q > 37'sd0;
      b4_q    <= b3_q[34:0];
      bb4_q   <= b3_q[34:0] * b3_q[34:0];
      rr4_q   <= r_q * r_q;
      vv4_q   <= vv3_q;
      ray5_q  <= ray4_q;
      b5_q    <= b4_q;
      hit5_q  <= bpos4_q && !disc5[72];
      disc5_q <= disc5[71:0];
    end
  end

  rsi_sq_side_t        sq_side_in, sq_side_out;
  logic                sq_vld;
  logic [SqrtBits-1:0] det;

  assign sq_side_in = '{hit: hit5_q, b: b5_q, ray: ray5_q};

  rsi_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_vld_q),
    .x_i     (disc5_q),
    .side_i  (sq_side_in),
    .valid_o (sq_vld),
    .root_o  (det),
    .side_o  (sq_side_out)
  );

  logic               t_vld_q, m_vld_q, p_vld_q, e_vld_q;
  logic               t_hit_q, m_hit_q, p_hit_q;
  logic               t_in_q, m_in_q, p_in_q;
  rsi_in_t            t_ray_q, m_ray_q;
  logic [36:0]        t_q, m_t_q;
  logic signed [39:0] td_q [3];
  logic signed [31:0] p_q [3];
  logic [30:0]        p_dist_q;
  logic [2:0][62:0]   num_q;
  rsi_div_side_t      e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv) begin
      t_vld_q <= sq_vld;
      m_vld_q <= t_vld_q;
      p_vld_q <= m_vld_q;
      e_vld_q <= p_vld_q;
    end
  end

  logic signed [37:0] near;
  logic signed [31:0] m_d [3];
  logic signed [31:0] m_o [3];
  logic signed [69:0] tprod [3];
  logic signed [40:0] psum [3];
  logic signed [31:0] psat [3];
  logic signed [32:0] e_diff [3];
  logic [32:0]        e_mag [3];

  assign near = 38'(sq_side_out.b) - 38'(det);
  assign m_d[0] = t_ray_q.dir_x;
  assign m_d[1] = t_ray_q.dir_y;
  assign m_d[2] = t_ray_q.dir_z;
  assign m_o[0] = m_ray_q.origin_x;
  assign m_o[1] = m_ray_q.origin_y;
  assign m_o[2] = m_ray_q.origin_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tprod[i] = $signed({33'd0, t_q}) * 70'(m_d[i]);
      psum[i]  = 41'(m_o[i]) + 41'(td_q[i]);
      if (psum[i] > 41'sd2147483647) begin
        psat[i] = 32'sh7fffffff;
      end else if (psum[i] < -41'sd2147483648) begin
        psat[i] = 32'sh80000000;
      end else begin
        psat[i] = psum[i][31:0];
      end
      e_diff[i] = 33'(p_q[i]) - 33'(c_q[i]);
      e_mag[i]  = e_diff[i][32] ? 33'(-e_diff[i]) : 33'(e_diff[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_hit_q <= sq_side_out.hit;
      t_ray_q <= sq_side_out.ray;
      if (near > 38'sd0) begin
        t_q    <= near[36:0];
        t_in_q <= 1'b0;
      end else begin
        t_q    <= 37'(sq_side_out.b) + 37'(det);
        t_in_q <= 1'b1;
      end
      m_hit_q <= t_hit_q;
      m_in_q  <= t_in_q;
      m_ray_q <= t_ray_q;
      m_t_q   <= t_q;
      for (int i = 0; i < 3; i++) begin
        td_q[i] <= tprod[i][69:30];
        p_q[i]  <= psat[i];
      end
      p_hit_q  <= m_hit_q;
      p_in_q   <= m_in_q;
      p_dist_q <= (m_t_q > 37'h7fffffff) ? 31'h7fffffff : m_t_q[30:0];
      e_side_q.hit      <= p_hit_q;
      e_side_q.inner    <= p_in_q;
      e_side_q.distance <= p_dist_q;
      for (int i = 0; i < 3; i++) begin
        e_side_q.p[i]   <= p_q[i];
        e_side_q.neg[i] <= e_diff[i][32] ^ p_in_q;
        e_side_q.ovf[i] <= {1'b0, e_mag[i], 30'd0} >= {r_q, 33'd0};
        num_q[i]        <= {e_mag[i], 30'd0};
      end
    end
  end

  logic                    dv_vld;
  logic [2:0][DivBits-1:0] quot;
  rsi_div_side_t           dv_side;

  rsi_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (e_vld_q),
    .radius_i (r_q),
    .num_i    (num_q),
    .side_i   (e_side_q),
    .valid_o  (dv_vld),
    .quot_o   (quot),
    .side_o   (dv_side)
  );

  logic               out_vld_q;
  rsi_out_t           out_q;
  logic signed [31:0] nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (r_q == '0 || !dv_side.hit) begin
        nrm[i] = '0;
      end else if (dv_side.neg[i]) begin
        nrm[i] = (dv_side.ovf[i] || quot[i] > 33'h080000000) ? 32'sh80000000
                                                             : 32'(-quot[i]);
      end else begin
        nrm[i] = (dv_side.ovf[i] || quot[i] > 33'h07fffffff) ? 32'sh7fffffff
                                                             : quot[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv_side.hit) begin
        out_q.hit        <= 1'b1;
        out_q.inside_res <= dv_side.inner;
        out_q.distance   <= dv_side.distance;
        out_q.hit_x      <= dv_side.p[0];
        out_q.hit_y      <= dv_side.p[1];
        out_q.hit_z      <= dv_side.p[2];
      end else begin
        out_q.hit        <= 1'b0;
        out_q.inside_res <= 1'b0;
        out_q.distance   <= '0;
        out_q.hit_x      <= '0;
        out_q.hit_y      <= '0;
        out_q.hit_z      <= '0;
      end
      out_q.normal_x <= nrm[0];
      out_q.normal_y <= nrm[1];
      out_q.normal_z <= nrm[2];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/rsi_checker.sv
module rsi_checker
  import rsi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input rsi_in_t     in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input rsi_out_t    out_data_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A stalled request keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

  // The input side only stalls while a result is held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A miss reports an all-zero result.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.distance == '0 &&
      !out_data_o.inside_res && out_data_o.hit_x == '0 && out_data_o.normal_x == '0)
    else $error("miss result not cleared");

  // A hit always lies strictly ahead of the origin.
  a_hit_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.distance != '0)
    else $error("hit with zero distance");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

>>> sim/tb_ray_sphere_intersect.sv
module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 100;
  localparam int RaysPerPhase  = 205;

  class hit_ledger;
    rsi_out_t    pending_hits[$];
    logic [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0] rad;
    int          errors, checked, hits, insides;

    function new();
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      rad   = 31'd65536;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        CfgCenterX: ctr_x = val;
        CfgCenterY: ctr_y = val;
        CfgCenterZ: ctr_z = val;
        CfgRadius:  rad   = val[30:0];
        default: ;
      endcase
    endfunction

    function wide_t sat32(wide_t x);
      if (x > wide_t'(64'sd2147483647)) return wide_t'(64'sd2147483647);
      if (x < -wide_t'(64'sd2147483648)) return -wide_t'(64'sd2147483648);
      return x;
    endfunction

    function rsi_out_t trace_ray(rsi_in_t ray);
      rsi_out_t res;
      wide_t o[3], d[3], c[3], v[3], p[3];
      wide_t b, lhs, vv, disc, root, cand, t, e, q, rr;
      logic inner, neg;
      res = '0;
      o[0] = wide_t'(ray.origin_x);
      o[1] = wide_t'(ray.origin_y);
      o[2] = wide_t'(ray.origin_z);
      d[0] = wide_t'(ray.dir_x);
      d[1] = wide_t'(ray.dir_y);
      d[2] = wide_t'(ray.dir_z);
      c[0] = wide_t'(signed'(ctr_x));
      c[1] = wide_t'(signed'(ctr_y));
      c[2] = wide_t'(signed'(ctr_z));
      rr = wide_t'({1'b0, rad});
      b = 0;
      vv = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = o[i] - c[i];
        b = b - ((v[i] * d[i]) >>> 30);
        vv = vv + v[i] * v[i];
      end
      if (b <= 0) return res;
      lhs = b * b + rr * rr;
      if (lhs < vv) return res;
      disc = lhs - vv;
      root = 0;
      for (int k = 40; k >= 0; k--) begin
        cand = root | (wide_t'(1) << k);
        if (cand * cand <= disc) root = cand;
      end
      if (b - root > 0) begin
        t = b - root;
        inner = 1'b0;
      end else begin
        t = b + root;
        inner = 1'b1;
      end
      res.hit = 1'b1;
      res.inside_res = inner;
      res.distance = (t > wide_t'(64'sd2147483647)) ? 31'h7fffffff : t[30:0];
      for (int i = 0; i < 3; i++) p[i] = sat32(o[i] + ((t * d[i]) >>> 30));
      res.hit_x = p[0][31:0];
      res.hit_y = p[1][31:0];
      res.hit_z = p[2][31:0];
      for (int i = 0; i < 3; i++) begin
        e = p[i] - c[i];
        if (rr == 0) begin
          q = 0;
        end else begin
          q = (((e < 0) ? -e : e) << 30) / rr;
          neg = (e < 0) != inner;
          if (neg) q = (q > wide_t'(64'sd2147483648)) ? -wide_t'(64'sd2147483648) : -q;
          else q = sat32(q);
        end
        case (i)
          0: res.normal_x = q[31:0];
          1: res.normal_y = q[31:0];
          default: res.normal_z = q[31:0];
        endcase
      end
      return res;
    endfunction

    function void note_ray(rsi_in_t ray);
      pending_hits.push_back(trace_ray(ray));
    endfunction

    function void check_hit(rsi_out_t got);
      rsi_out_t exp_r;
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no request pending: %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_hits.pop_front();
      checked++;
      hits += exp_r.hit;
      insides += exp_r.inside_res;
      if (got.hit !== exp_r.hit)
        report("hit", exp_r.hit, got.hit);
      if (got.inside_res !== exp_r.inside_res)
        report("inside_res", exp_r.inside_res, got.inside_res);
      if (got.distance !== exp_r.distance)
        report("distance", exp_r.distance, got.distance);
      if (got.hit_x !== exp_r.hit_x) report("hit_x", exp_r.hit_x, got.hit_x);
      if (got.hit_y !== exp_r.hit_y) report("hit_y", exp_r.hit_y, got.hit_y);
      if (got.hit_z !== exp_r.hit_z) report("hit_z", exp_r.hit_z, got.hit_z);
      if (got.normal_x !== exp_r.normal_x) report("normal_x", exp_r.normal_x, got.normal_x);
      if (got.normal_y !== exp_r.normal_y) report("normal_y", exp_r.normal_y, got.normal_y);
      if (got.normal_z !== exp_r.normal_z) report("normal_z", exp_r.normal_z, got.normal_z);
    endfunction

    function void report(string fld, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t: %s expected %h actual %h", $time, fld, exp_v, got_v);
      errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  rsi_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsi_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  hit_ledger ledger = new();
  bit        quiet;
  int        idle_cycles;
  int        stall_left;

  ray_sphere_intersect dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) ledger.check_hit(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results pending", ledger.pending_hits.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_ray(rsi_in_t ray);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ray;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_ray(ray);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_reg(idx, val);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (ledger.pending_hits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] r);
    drain();
    write_reg(CfgCenterX, cx);
    write_reg(CfgCenterY, cy);
    write_reg(CfgCenterZ, cz);
    write_reg(CfgRadius, r);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] to_fix(real x);
    if (x > 2147483647.0) return 32'h7fffffff;
    if (x < -2147483648.0) return 32'h80000000;
    return 32'(longint'(x));
  endfunction

  function automatic rsi_in_t aimed_ray();
    rsi_in_t ray;
    real c[3], o[3], d[3], r, len;
    c[0] = $itor(signed'(ledger.ctr_x));
    c[1] = $itor(signed'(ledger.ctr_y));
    c[2] = $itor(signed'(ledger.ctr_z));
    r = $itor(ledger.rad) + 1.0;
    len = 0.0;
    for (int i = 0; i < 3; i++) begin
      o[i] = c[i] + r * ($itor($urandom_range(0, 8000)) / 1000.0 - 4.0);
      if (o[i] > 2147483647.0) o[i] = 2147483647.0;
      if (o[i] < -2147483648.0) o[i] = -2147483648.0;
      d[i] = c[i] + r * ($itor($urandom_range(0, 2400)) / 1000.0 - 1.2) - o[i];
      len += d[i] * d[i];
    end
    len = $sqrt(len);
    if (len < 1.0e-9) begin
      d[0] = 0.0;
      d[1] = 0.0;
      d[2] = 1.0;
      len = 1.0;
    end
    ray.origin_x = to_fix(o[0]);
    ray.origin_y = to_fix(o[1]);
    ray.origin_z = to_fix(o[2]);
    ray.dir_x = to_fix(d[0] / len * 1073741824.0);
    ray.dir_y = to_fix(d[1] / len * 1073741824.0);
    ray.dir_z = to_fix(d[2] / len * 1073741824.0);
    return ray;
  endfunction

  function automatic rsi_in_t mk(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                 logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    rsi_in_t ray;
    ray = {ox, oy, oz, dx, dy, dz};
    return ray;
  endfunction

  task automatic random_rays(int count);
    rsi_in_t ray;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 80) begin
        ray = aimed_ray();
      end else begin
        ray = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end
      send_ray(ray);
    end
  endtask

  localparam logic [31:0] One  = 32'h0001_0000;
  localparam logic [31:0] Unit = 32'h4000_0000;

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_ray(mk(0, 0, -5 * One, 0, 0, Unit));
    send_ray(mk(0, 0, 0, Unit, 0, 0));
    send_ray(mk(0, 0, 5 * One, 0, 0, Unit));
    send_ray(mk(0, 2 * One, -5 * One, 0, 0, Unit));
    send_ray(mk(0, One, -5 * One, 0, 0, Unit));
    send_ray(mk(0, 0, -5 * One, 0, 0, 32'h7fffffff));
    send_ray(mk(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_ray(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000));
    send_ray(mk(32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
    send_ray(mk(0, 0, 0, 0, 0, 0));
    send_ray(mk(One / 2, 0, 0, 32'hc000_0000, 0, 0));
    send_ray(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, Unit, Unit, Unit));
    random_rays(RaysPerPhase);

    load_sphere(3 * One, -2 * One, 10 * One, 32'h0002_8000);
    write_reg(8'd4, 32'hdeadbeef);
    write_reg(8'hff, 32'h1234_5678);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    random_rays(RaysPerPhase);

    quiet = 1'b1;
    load_sphere(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
    random_rays(RaysPerPhase);
    quiet = 1'b0;

    load_sphere($urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20), 0, 1);
    random_rays(RaysPerPhase / 2);
    drain();
    random_rays(RaysPerPhase / 2);

    load_sphere(5 * One, One, -One, 0);
    send_ray(mk(5 * One, One, -5 * One, 0, 0, Unit));
    random_rays(RaysPerPhase);

    load_sphere($urandom(), $urandom(), $urandom(), $urandom());
    random_rays(RaysPerPhase);

    quiet = 1'b1;
    load_sphere(-100 * One, 50 * One, 0, 40 * One);
    random_rays(RaysPerPhase);
    quiet = 1'b0;

    load_sphere($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                -$urandom_range(0, 1 << 24), $urandom_range(1, 1 << 22));
    random_rays(RaysPerPhase);

    drain();
    $display("Checked %0d results over eight sphere settings: %0d hits, %0d from inside.",
             ledger.checked, ledger.hits, ledger.insides);
    if (ledger.errors == 0 && ledger.pending_hits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rsi_pkg.sv
hdl/rsi_isqrt.sv
hdl/rsi_div.sv
hdl/ray_sphere_intersect.sv
hdl/rsi_checker.sv
sim/tb_ray_sphere_intersect.sv
